// File: rtl/tdls_pkg.sv
// Package for the line-sampling capture core: field widths, command and
// register codes, the result record and the fixed table of sample lines.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package tdls_pkg;

   localparam int CMD_W       = 2;
   localparam int PIXEL_W     = 8;
   localparam int ROW_W       = 6;
   localparam int COL_W       = 7;
   localparam int PPR_W       = 8;
   localparam int LINE_W      = 10;
   localparam int ROWS_W      = 7;
   localparam int ENTRY_W     = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   localparam int TABLE_DEPTH = 64;
   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLUMNS = 128;

   localparam logic [PPR_W-1:0]  PPR_RESET        = PPR_W'(80);
   localparam logic [LINE_W-1:0] LINE_LIMIT_RESET = LINE_W'(240);
   localparam logic [ROWS_W-1:0] ROWS_USED_RESET  = ROWS_W'(60);
   localparam logic [PPR_W-1:0]  COLUMN_CAP       = PPR_W'(MAX_COLUMNS);
   localparam logic [ROWS_W-1:0] ROW_CAP          = ROWS_W'(MAX_ROWS);

   typedef enum logic [CMD_W-1:0] {
      CMD_FRAME_START = 2'd0,
      CMD_LINE_START  = 2'd1,
      CMD_PIXEL       = 2'd2,
      CMD_RELEASE     = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PIXELS_PER_ROW = 2'd0,
      CSR_LINE_LIMIT     = 2'd1,
      CSR_ROWS_USED      = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic               write_valid;
      logic [ROW_W-1:0]   write_row;
      logic [COL_W-1:0]   write_column;
      logic [PIXEL_W-1:0] write_pixel;
      logic               frame_done;
      logic               sampling_active;
      logic               processing_locked;
   } rsp_type;

   localparam logic [ENTRY_W-1:0] LINE_TABLE [TABLE_DEPTH] = '{
      8'd1,   8'd5,   8'd10,  8'd16,  8'd20,  8'd31,  8'd40,  8'd45,
      8'd57,  8'd62,  8'd68,  8'd79,  8'd88,  8'd97,  8'd105, 8'd112,
      8'd119, 8'd126, 8'd132, 8'd137, 8'd143, 8'd148, 8'd152, 8'd157,
      8'd161, 8'd165, 8'd169, 8'd172, 8'd176, 8'd179, 8'd182, 8'd185,
      8'd188, 8'd190, 8'd193, 8'd195, 8'd198, 8'd200, 8'd202, 8'd204,
      8'd206, 8'd208, 8'd210, 8'd213, 8'd215, 8'd217, 8'd218, 8'd220,
      8'd221, 8'd223, 8'd224, 8'd225, 8'd227, 8'd228, 8'd229, 8'd231,
      8'd233, 8'd234, 8'd236, 8'd237, 8'd0,   8'd0,   8'd0,   8'd0
   };

endpackage

`default_nettype wire

// File: rtl/tdls_req_if.sv
// Event input channel of the capture core: command and pixel byte.
// Depends on tdls_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tdls_req_if
   import tdls_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [PIXEL_W-1:0] pixel_value;

   modport source (output valid, output command, output pixel_value, input ready);
   modport sink   (input valid, input command, input pixel_value, output ready);
endinterface

`default_nettype wire

// File: rtl/tdls_rsp_if.sv
// Result channel of the capture core: pixel write and frame status.
// Depends on tdls_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tdls_rsp_if
   import tdls_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               write_valid;
   logic [ROW_W-1:0]   write_row;
   logic [COL_W-1:0]   write_column;
   logic [PIXEL_W-1:0] write_pixel;
   logic               frame_done;
   logic               sampling_active;
   logic               processing_locked;

   modport source (output valid, output write_valid, output write_row, output write_column,
                   output write_pixel, output frame_done, output sampling_active,
                   output processing_locked, input ready);
   modport sink   (input valid, input write_valid, input write_row, input write_column,
                   input write_pixel, input frame_done, input sampling_active,
                   input processing_locked, output ready);
endinterface

`default_nettype wire

// File: rtl/tdls_csr_if.sv
// Register write channel of the capture core: register index and data.
// Depends on tdls_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tdls_csr_if
   import tdls_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/table_driven_line_sampling_capture_core.sv
// Line-sampling capture core: frame, line, pixel and release events in,
// one status record, with an optional frame-memory write, out per event.
// Depends on tdls_pkg, tdls_req_if, tdls_rsp_if and tdls_csr_if.
//
// Each transfer on req_bus carries one event; each produces exactly one
// transfer on rsp_bus, in order, in the cycle after acceptance at the earliest.
// The core accepts one event per cycle while the receiver is not stalling.
// The sample-line table sits in a 64-entry ROM with a registered read port;
// its address is the next row counter, so the entry for the current row is
// always ready when a line start arrives. A single output register holds
// the result; req_bus.ready stays high while that register is empty or being
// drained, so a stalled receiver holds the result and blocks new events only
// while it stalls. Register writes on csr_bus are always taken and apply to
// the next event; writes to an index beyond the register list are dropped.
// Synchronous reset loads the register defaults, clears the counters,
// closes sampling, releases the lock and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module table_driven_line_sampling_capture_core
   import tdls_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   tdls_req_if.sink   req_bus,
   tdls_rsp_if.source rsp_bus,
   tdls_csr_if.sink   csr_bus
);

   logic [PPR_W-1:0]   pixels_per_row_ff;
   logic [LINE_W-1:0]  line_limit_ff;
   logic [ROWS_W-1:0]  rows_used_ff;

   logic [LINE_W-1:0]  line_counter_ff, line_counter_in;
   logic [ROWS_W-1:0]  row_counter_ff, row_counter_in;
   logic [COL_W-1:0]   column_counter_ff, column_counter_in;
   logic [ROW_W-1:0]   armed_row_ff, armed_row_in;
   logic               capture_armed_ff, capture_armed_in;
   logic               sampling_ff, sampling_in;
   logic               processing_ff, processing_in;

   logic [ENTRY_W-1:0] table_entry_ff;
   logic [ROW_W-1:0]   table_addr;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   logic               req_accept;
   logic [PPR_W-1:0]   column_bound;
   logic [PPR_W-1:0]   column_sum;
   logic               line_hit;
   cmd_type            command;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign command       = cmd_type'(req_bus.command);

   assign column_bound = (pixels_per_row_ff > COLUMN_CAP) ? COLUMN_CAP : pixels_per_row_ff;
   assign column_sum   = {1'b0, column_counter_ff} + PPR_W'(1);
   assign line_hit     = !row_counter_ff[ROWS_W-1] &&
                         (line_counter_ff == {{(LINE_W-ENTRY_W){1'b0}}, table_entry_ff});

   always_comb begin
      line_counter_in   = line_counter_ff;
      row_counter_in    = row_counter_ff;
      column_counter_in = column_counter_ff;
      armed_row_in      = armed_row_ff;
      capture_armed_in  = capture_armed_ff;
      sampling_in       = sampling_ff;
      processing_in     = processing_ff;
      rsp_in            = '0;
      if (req_accept) begin
         unique case (command)
            CMD_FRAME_START: begin
               if (!processing_ff) begin
                  sampling_in       = 1'b1;
                  line_counter_in   = '0;
                  row_counter_in    = '0;
                  column_counter_in = '0;
                  capture_armed_in  = 1'b0;
               end
            end
            CMD_LINE_START: begin
               if (sampling_ff) begin
                  capture_armed_in = 1'b0;
                  if (line_hit) begin
                     armed_row_in      = row_counter_ff[ROW_W-1:0];
                     column_counter_in = '0;
                     capture_armed_in  = (column_bound != '0);
                     row_counter_in    = row_counter_ff + ROWS_W'(1);
                  end
                  line_counter_in = line_counter_ff + LINE_W'(1);
                  if (line_counter_in >= line_limit_ff || row_counter_in >= rows_used_ff ||
                      row_counter_in >= ROW_CAP) begin
                     sampling_in       = 1'b0;
                     processing_in     = 1'b1;
                     rsp_in.frame_done = 1'b1;
                  end
               end
            end
            CMD_PIXEL: begin
               if (capture_armed_ff) begin
                  rsp_in.write_valid  = 1'b1;
                  rsp_in.write_row    = armed_row_ff;
                  rsp_in.write_column = column_counter_ff;
                  rsp_in.write_pixel  = req_bus.pixel_value;
                  if (column_sum >= column_bound) begin
                     capture_armed_in  = 1'b0;
                     column_counter_in = '0;
                  end else begin
                     column_counter_in = column_sum[COL_W-1:0];
                  end
               end
            end
            CMD_RELEASE: begin
               processing_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
      rsp_in.sampling_active   = sampling_in;
      rsp_in.processing_locked = processing_in;
   end

   assign table_addr = reset ? '0 : row_counter_in[ROW_W-1:0];

   always_ff @(posedge clock) begin
      table_entry_ff <= LINE_TABLE[table_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixels_per_row_ff <= PPR_RESET;
         line_limit_ff     <= LINE_LIMIT_RESET;
         rows_used_ff      <= ROWS_USED_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_PIXELS_PER_ROW: pixels_per_row_ff <= csr_bus.data[PPR_W-1:0];
            CSR_LINE_LIMIT:     line_limit_ff     <= csr_bus.data[LINE_W-1:0];
            CSR_ROWS_USED:      rows_used_ff      <= csr_bus.data[ROWS_W-1:0];
            CSR_UNUSED: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_counter_ff   <= '0;
         row_counter_ff    <= '0;
         column_counter_ff <= '0;
         armed_row_ff      <= '0;
         capture_armed_ff  <= 1'b0;
         sampling_ff       <= 1'b0;
         processing_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         line_counter_ff   <= line_counter_in;
         row_counter_ff    <= row_counter_in;
         column_counter_ff <= column_counter_in;
         armed_row_ff      <= armed_row_in;
         capture_armed_ff  <= capture_armed_in;
         sampling_ff       <= sampling_in;
         processing_ff     <= processing_in;
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.write_valid       = rsp_ff.write_valid;
   assign rsp_bus.write_row         = rsp_ff.write_row;
   assign rsp_bus.write_column      = rsp_ff.write_column;
   assign rsp_bus.write_pixel       = rsp_ff.write_pixel;
   assign rsp_bus.frame_done        = rsp_ff.frame_done;
   assign rsp_bus.sampling_active   = rsp_ff.sampling_active;
   assign rsp_bus.processing_locked = rsp_ff.processing_locked;

endmodule

`default_nettype wire

// File: rtl/tdls_checker.sv
// Port-level checker for the capture core and the bind that attaches it.
// Depends on tdls_pkg and on table_driven_line_sampling_capture_core.
`timescale 1ns / 1ps
`default_nettype none

module tdls_checker
   import tdls_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               write_valid,
   input wire logic [ROW_W-1:0]   write_row,
   input wire logic [COL_W-1:0]   write_column,
   input wire logic [PIXEL_W-1:0] write_pixel,
   input wire logic               frame_done,
   input wire logic               sampling_active,
   input wire logic               processing_locked
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(write_valid) && $stable(write_row) &&
         $stable(write_column) && $stable(write_pixel) && $stable(frame_done) &&
         $stable(sampling_active) && $stable(processing_locked))
      else $error("result changed while the receiver stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_done |-> processing_locked && !sampling_active && !write_valid)
      else $error("frame close without lock");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(sampling_active && processing_locked))
      else $error("sampling open while frame is locked");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !write_valid |-> write_row == '0 && write_column == '0 &&
         write_pixel == '0)
      else $error("write fields set without a pixel write");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result present right after reset");

endmodule

bind table_driven_line_sampling_capture_core tdls_checker u_tdls_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .write_valid       (rsp_bus.write_valid),
   .write_row         (rsp_bus.write_row),
   .write_column      (rsp_bus.write_column),
   .write_pixel       (rsp_bus.write_pixel),
   .frame_done        (rsp_bus.frame_done),
   .sampling_active   (rsp_bus.sampling_active),
   .processing_locked (rsp_bus.processing_locked)
);

`default_nettype wire
